// ===== rtl/core/packed_delta_triangle_strip_decoder_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PACKED_DELTA_TRIANGLE_STRIP_DECODER_CORE_DEFINES_SVH
`define PACKED_DELTA_TRIANGLE_STRIP_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PDTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define PDTS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pdts_pkg.sv =====
package pdts_pkg;

    localparam int INDEX_WIDTH   = 32;
    localparam int BYTE_BITS     = 8;
    localparam int STRIP_CORNERS = 3;

    localparam int CORNER_W = 32;
    localparam int BUF_W    = 40;
    localparam int HELD_W   = 6;
    localparam int CNT_W    = 31;
    localparam int CFG_W    = 6;
    localparam int APB_W    = 32;
    localparam int APB_ADDR_W = 3;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic             OP_BEGIN = 1'b0;
    localparam logic             OP_DATA  = 1'b1;
    localparam logic             REG_INDEX_BITS = 1'b0;
    localparam logic [CFG_W-1:0] INDEX_BITS_RESET = CFG_W'(8);

    localparam int FIELD_CAP_INT = (INDEX_WIDTH < 32) ? INDEX_WIDTH : 32;
    localparam logic [HELD_W-1:0] FIELD_CAP = HELD_W'(FIELD_CAP_INT);
    localparam logic [CORNER_W-1:0] IDX_MASK = {CORNER_W{1'b1}} >> (CORNER_W - INDEX_WIDTH);

    typedef struct packed {
        logic             op;
        logic [CNT_W-1:0] arg;
    } t_cmd;

    typedef struct packed {
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic                last_of_run;
    } t_tri;

    function automatic logic [HELD_W-1:0] field_width(input logic [CFG_W-1:0] bits);
        logic [HELD_W-1:0] w;
        w = HELD_W'(bits);
        if (w == '0) begin
            w = HELD_W'(1);
        end else if (w > FIELD_CAP) begin
            w = FIELD_CAP;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/pdts_if.sv =====
interface pdts_in_if import pdts_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             opcode;
    logic [CNT_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

interface pdts_out_if import pdts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
    logic                last_of_run;

    modport source (output valid, output corner_a, output corner_b, output corner_c,
                    output last_of_run, input ready);
    modport sink (input valid, input corner_a, input corner_b, input corner_c,
                  input last_of_run, output ready);
endinterface

// ===== rtl/core/pdts_front.sv =====
module pdts_front import pdts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pdts_in_if.sink               i_in,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]      prdata,
    output logic                  pready,
    output logic                  o_push_valid,
    output t_cmd                  o_push_cmd,
    input  logic                  i_push_ready,
    output logic [HELD_W-1:0]     o_field_width
);

    logic [CFG_W-1:0] r_index_bits;
    logic [CFG_W-1:0] n_index_bits;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_INDEX_BITS);

    always_comb begin
        n_index_bits = r_index_bits;
        if (cfg_wr) begin
            n_index_bits = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= INDEX_BITS_RESET;
        end else begin
            r_index_bits <= n_index_bits;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INDEX_BITS) ? APB_W'(r_index_bits) : '0;
    assign o_field_width = field_width(r_index_bits);

    // A data item only ever carries its low byte onward.
    always_comb begin
        o_push_cmd.op = i_in.opcode;
        if (i_in.opcode == OP_BEGIN) begin
            o_push_cmd.arg = i_in.value;
        end else begin
            o_push_cmd.arg = CNT_W'(i_in.value[BYTE_BITS-1:0]);
        end
    end

    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

endmodule

// ===== rtl/core/pdts_queue.sv =====
module pdts_queue import pdts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cmd i_push_cmd,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_cmd o_pop_cmd,
    input  logic i_pop
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== rtl/core/pdts_back.sv =====
module pdts_back import pdts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    input  t_cmd              i_pop_cmd,
    output logic              o_pop,
    input  logic [HELD_W-1:0] i_field_width,
    pdts_out_if.source        o_out
);

    logic [BUF_W-1:0]    r_buf,       n_buf;
    logic [HELD_W-1:0]   r_held,      n_held;
    logic [CORNER_W-1:0] r_run,       n_run;
    logic [CORNER_W-1:0] r_older,     n_older;
    logic [CORNER_W-1:0] r_newer,     n_newer;
    logic [CNT_W-1:0]    r_left,      n_left;
    logic [CNT_W-1:0]    r_pos,       n_pos;
    logic                r_busy,      n_busy;
    logic                r_out_valid, n_out_valid;
    t_tri                r_out,       n_out;

    logic                out_free;
    logic                is_begin;
    logic                append;
    logic                live;
    logic [BUF_W-1:0]    v_buf;
    logic [HELD_W-1:0]   v_held;
    logic                can_ext;
    logic                emits;
    logic                do_ext;
    logic [HELD_W-1:0]   shamt;
    logic [BUF_W-1:0]    shifted;
    logic [CORNER_W-1:0] fmask;
    logic [CORNER_W-1:0] z;
    logic [CORNER_W-1:0] delta;
    logic [CORNER_W-1:0] fresh;
    logic [HELD_W-1:0]   held_after;
    logic [CNT_W-1:0]    left_after;
    logic                more;

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = !r_busy && i_pop_valid;
    assign is_begin = o_pop && (i_pop_cmd.op == OP_BEGIN);
    assign append   = o_pop && (i_pop_cmd.op == OP_DATA) && (r_left != '0);
    assign live     = r_busy || append;

    assign v_buf  = append ? {r_buf[BUF_W-BYTE_BITS-1:0], i_pop_cmd.arg[BYTE_BITS-1:0]} : r_buf;
    assign v_held = append ? r_held + HELD_W'(BYTE_BITS) : r_held;

    assign can_ext = live && (v_held >= i_field_width) && (r_left != '0);
    assign emits   = (r_pos >= CNT_W'(STRIP_CORNERS - 1));
    assign do_ext  = can_ext && (!emits || out_free);

    // One field a cycle unless the output stalls; MSB first, then undo zigzag.
    assign shamt   = v_held - i_field_width;
    assign shifted = v_buf >> shamt;
    assign fmask   = {CORNER_W{1'b1}} >> (HELD_W'(CORNER_W) - i_field_width);
    assign z       = shifted[CORNER_W-1:0] & fmask;
    assign delta   = (z >> 1) ^ {CORNER_W{z[0]}};
    assign fresh   = (r_run + delta) & IDX_MASK;

    assign held_after = do_ext ? v_held - i_field_width : v_held;
    assign left_after = do_ext ? r_left - CNT_W'(1) : r_left;
    assign more       = (held_after >= i_field_width) && (left_after != '0);

    always_comb begin
        n_buf   = r_buf;
        n_held  = r_held;
        n_run   = r_run;
        n_older = r_older;
        n_newer = r_newer;
        n_left  = r_left;
        n_pos   = r_pos;
        n_busy  = r_busy;
        if (is_begin) begin
            n_buf   = '0;
            n_held  = '0;
            n_run   = '0;
            n_older = '0;
            n_newer = '0;
            n_pos   = '0;
            n_left  = i_pop_cmd.arg;
            n_busy  = 1'b0;
        end else if (live) begin
            if (do_ext) begin
                n_run   = fresh;
                n_older = r_newer;
                n_newer = fresh;
                n_pos   = r_pos + CNT_W'(1);
                n_left  = left_after;
            end
            if (left_after == '0) begin
                n_buf  = '0;
                n_held = '0;
                n_busy = 1'b0;
            end else begin
                n_buf  = v_buf;
                n_held = held_after;
                n_busy = more;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (do_ext && emits) begin
            n_out_valid       = 1'b1;
            n_out.corner_a    = r_older;
            n_out.corner_b    = r_pos[0] ? fresh : r_newer;
            n_out.corner_c    = r_pos[0] ? r_newer : fresh;
            n_out.last_of_run = !more;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf       <= '0;
            r_held      <= '0;
            r_run       <= '0;
            r_older     <= '0;
            r_newer     <= '0;
            r_left      <= '0;
            r_pos       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_buf       <= n_buf;
            r_held      <= n_held;
            r_run       <= n_run;
            r_older     <= n_older;
            r_newer     <= n_newer;
            r_left      <= n_left;
            r_pos       <= n_pos;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.corner_a    = r_out.corner_a;
    assign o_out.corner_b    = r_out.corner_b;
    assign o_out.corner_c    = r_out.corner_c;
    assign o_out.last_of_run = r_out.last_of_run;

endmodule

// ===== rtl/core/packed_delta_triangle_strip_decoder_core.sv =====
// Triangle-strip index decoder for a bit-packed stream of zigzag-coded deltas.
// Input channel i_in: opcode 0 begins a strip and carries the index count in
// value; opcode 1 carries one packed data byte in the low 8 bits of value.
// Output channel o_out: one item per triangle, corners with winding applied,
// and last_of_run set on the final triangle that a data byte produces.
// The APB port holds index_bits at address 0; write it only while idle.
// A byte goes through the queue; its results are held in the output register.
// Throughput: one input item per cycle while each byte yields at most one
// index and the output is not stalled; the back end extracts one field per
// cycle, and the four-entry queue absorbs the difference.
// A stalled receiver holds the output register; the back end then stops at
// the next triangle while the front keeps accepting until the queue fills.
// Reset sets index_bits to 8, clears all strip state and empties the queue.
module packed_delta_triangle_strip_decoder_core import pdts_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pdts_in_if.sink               i_in,
    pdts_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]      prdata,
    output logic                  pready
);

    logic              push_valid;
    t_cmd              push_cmd;
    logic              push_ready;
    logic              pop_valid;
    t_cmd              pop_cmd;
    logic              pop;
    logic [HELD_W-1:0] field_w;

    pdts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_push_valid  (push_valid),
        .o_push_cmd    (push_cmd),
        .i_push_ready  (push_ready),
        .o_field_width (field_w)
    );

    pdts_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop        (pop)
    );

    pdts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (pop_valid),
        .i_pop_cmd     (pop_cmd),
        .o_pop         (pop),
        .i_field_width (field_w),
        .o_out         (o_out)
    );

endmodule

// ===== rtl/core/pdts_checker.sv =====
`include "packed_delta_triangle_strip_decoder_core_defines.svh"

module pdts_checker import pdts_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    pdts_in_if.sink              i_in,
    pdts_out_if.source           o_out,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_W-1:0]      pwdata,
    input logic [APB_W-1:0]      prdata,
    input logic                  pready
);

    `PDTS_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid, "output item dropped while stalled")
    `PDTS_ASSERT_NEXT(a_out_payload_holds, i_clk, i_rst_n, o_out.valid && !o_out.ready, $stable(o_out.corner_a) && $stable(o_out.corner_b) && $stable(o_out.corner_c) && $stable(o_out.last_of_run), "output item changed while stalled")
    `PDTS_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_out.valid && i_in.ready, "block not idle after reset")
    `PDTS_ASSERT_NEXT(a_cfg_readback, i_clk, i_rst_n, psel && penable && pwrite && pready && (paddr[2] == REG_INDEX_BITS), prdata == APB_W'($past(pwdata[CFG_W-1:0])), "index_bits readback mismatch")

endmodule

bind packed_delta_triangle_strip_decoder_core pdts_checker u_pdts_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pdts_pkg::*;

    localparam int RANDOM_ITEMS  = 270;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RUN_MAX       = 8;
    localparam int WIDTH_CAP     = (INDEX_WIDTH < 32) ? INDEX_WIDTH : 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_INDEX_BITS = {REG_INDEX_BITS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED     = APB_ADDR_W'(4);

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_W-1:0] pwdata;
    logic [APB_W-1:0] prdata;
    logic pready;
    logic sink_ready = 1'b0;

    pdts_in_if in_if ();
    pdts_out_if out_if ();

    assign out_if.ready = sink_ready;

    packed_delta_triangle_strip_decoder_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Decoder state as the block should hold it.
    logic [CFG_W-1:0]    field_bits;
    logic [BUF_W-1:0]    pack_buf;
    logic [HELD_W-1:0]   pack_held;
    logic [CORNER_W-1:0] run_index;
    logic [CORNER_W-1:0] older_vtx;
    logic [CORNER_W-1:0] newer_vtx;
    logic [CNT_W-1:0]    left_count;
    logic [CNT_W-1:0]    strip_pos;

    t_tri pending_triangles[$];
    int   mismatch_cnt;
    int   useful_items;
    int   stall_left;
    int   cycle_cnt;
    bit   steady_flow;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        mismatch_cnt++;
    endtask

    function automatic void restart_strip();
        pack_buf  = '0;
        pack_held = '0;
        run_index = '0;
        older_vtx = '0;
        newer_vtx = '0;
        strip_pos = '0;
    endfunction

    function automatic logic [HELD_W-1:0] active_width();
        logic [HELD_W-1:0] w;
        w = HELD_W'(field_bits);
        if (w == '0) begin
            w = HELD_W'(1);
        end else if (w > WIDTH_CAP) begin
            w = HELD_W'(WIDTH_CAP);
        end
        return w;
    endfunction

    // Returns 1 when the item is not simply dropped as padding.
    function automatic bit decode_item(input logic op, input logic [CNT_W-1:0] val);
        logic [HELD_W-1:0]   nb;
        logic [63:0]         z;
        logic [63:0]         delta;
        logic [CORNER_W-1:0] fresh;
        t_tri                run_tris[RUN_MAX];
        int                  n_new;

        if (op == OP_BEGIN) begin
            restart_strip();
            left_count = val;
            return 1'b1;
        end
        if (left_count == '0) begin
            return 1'b0;
        end
        n_new = 0;
        nb = active_width();
        pack_buf = {pack_buf[BUF_W-BYTE_BITS-1:0], val[BYTE_BITS-1:0]};
        pack_held = pack_held + HELD_W'(BYTE_BITS);
        while (pack_held >= nb && left_count != '0) begin
            pack_held = pack_held - nb;
            z = 64'(pack_buf >> pack_held) & ((64'd1 << nb) - 64'd1);
            if (z[0]) begin
                delta = 64'd0 - ((z + 64'd1) >> 1);
            end else begin
                delta = z >> 1;
            end
            fresh = (run_index + delta[CORNER_W-1:0]) & IDX_MASK;
            run_index = fresh;
            if (strip_pos >= STRIP_CORNERS - 1 && n_new < RUN_MAX) begin
                run_tris[n_new].corner_a = older_vtx;
                if (!strip_pos[0]) begin
                    run_tris[n_new].corner_b = newer_vtx;
                    run_tris[n_new].corner_c = fresh;
                end else begin
                    run_tris[n_new].corner_b = fresh;
                    run_tris[n_new].corner_c = newer_vtx;
                end
                run_tris[n_new].last_of_run = 1'b0;
                n_new++;
            end
            older_vtx = newer_vtx;
            newer_vtx = fresh;
            strip_pos = strip_pos + 1'b1;
            left_count = left_count - 1'b1;
        end
        if (left_count == '0) begin
            pack_buf  = '0;
            pack_held = '0;
        end else begin
            pack_buf = pack_buf & ((BUF_W'(1) << pack_held) - BUF_W'(1));
        end
        if (n_new > 0) begin
            run_tris[n_new - 1].last_of_run = 1'b1;
        end
        for (int k = 0; k < n_new; k++) begin
            pending_triangles.push_back(run_tris[k]);
        end
        return 1'b1;
    endfunction

    task automatic send_item(input logic op, input logic [CNT_W-1:0] val);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.opcode <= op;
        in_if.value  <= val;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (decode_item(op, val)) begin
            useful_items++;
        end
    endtask

    task automatic send_word(input logic [31:0] word);
        for (int k = 3; k >= 0; k--) begin
            send_item(OP_DATA, CNT_W'(word[8*k +: 8]));
        end
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_triangles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [APB_W-1:0] data);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_INDEX_BITS) begin
            field_bits = data[CFG_W-1:0];
        end
    endtask

    function automatic logic [CNT_W-1:0] random_byte_value();
        logic [CNT_W-BYTE_BITS-1:0] upper;
        upper = ($urandom_range(0, 7) == 0) ? (CNT_W-BYTE_BITS)'($urandom()) : '0;
        return {upper, BYTE_BITS'($urandom())};
    endfunction

    task automatic test_default_width();
        send_item(OP_BEGIN, CNT_W'(4));
        send_item(OP_DATA, CNT_W'(8'h00));
        send_item(OP_DATA, CNT_W'(8'hFF));
        send_item(OP_DATA, CNT_W'(8'hFE));
        send_item(OP_DATA, {23'h7FFFFF, 8'h01});
        send_item(OP_DATA, {23'h7FFFFF, 8'hFF});
    endtask

    task automatic test_single_bit_fields();
        write_reg(ADDR_INDEX_BITS, 32'hFFFF_FFC1);
        send_item(OP_BEGIN, CNT_W'(12));
        send_item(OP_DATA, CNT_W'(8'hA5));
        send_item(OP_DATA, CNT_W'(8'h3C));
        send_item(OP_BEGIN, CNT_W'(2));
        send_item(OP_DATA, CNT_W'(8'hFF));
        send_item(OP_BEGIN, CNT_W'(0));
        send_item(OP_DATA, CNT_W'(8'h5A));
        write_reg(ADDR_INDEX_BITS, '0);
        send_item(OP_BEGIN, CNT_W'(9));
        send_item(OP_DATA, CNT_W'(8'hFF));
        send_item(OP_DATA, CNT_W'(8'h80));
    endtask

    task automatic test_full_width_fields();
        write_reg(ADDR_INDEX_BITS, 32'd33);
        write_reg(ADDR_UNUSED, 32'd5);
        send_item(OP_BEGIN, CNT_W'(3));
        send_word(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFE);
        send_word(32'h0000_0004);
        send_item(OP_DATA, CNT_W'(8'h00));
    endtask

    task automatic test_random_strips();
        int pick;
        int width;
        int kind;
        int n_strips;
        int n_bytes;
        logic [CNT_W-1:0] count;

        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    width = 0;
                end
                1: begin
                    width = $urandom_range(33, 63);
                end
                2: begin
                    width = 32;
                end
                3: begin
                    width = 1;
                end
                9: begin
                    width = $urandom_range(13, 31);
                end
                default: begin
                    width = $urandom_range(2, 12);
                end
            endcase
            write_reg(ADDR_INDEX_BITS, {($urandom_range(0, 3) == 0) ? 26'($urandom()) : 26'd0,
                                        6'(width)});
            if ($urandom_range(0, 7) == 0) begin
                write_reg(ADDR_UNUSED, $urandom());
            end
            steady_flow = ($urandom_range(0, 3) == 0);
            n_strips = $urandom_range(1, 4);
            repeat (n_strips) begin
                kind = $urandom_range(0, 9);
                if (kind == 8) begin
                    count = '0;
                    n_bytes = $urandom_range(1, 3);
                end else if (kind == 9) begin
                    count = CNT_W'($urandom());
                    n_bytes = $urandom_range(1, 12);
                end else begin
                    count = CNT_W'($urandom_range(1, 24));
                    n_bytes = (int'(count) * int'(active_width()) + 7) / 8;
                    if (kind == 7) begin
                        n_bytes = $urandom_range(0, n_bytes - 1);
                    end else begin
                        n_bytes += $urandom_range(0, 2);
                    end
                end
                send_item(OP_BEGIN, count);
                repeat (n_bytes) send_item(OP_DATA, random_byte_value());
            end
        end
        steady_flow = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_tri want;
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
            stall_left = 0;
        end else if (out_if.valid && sink_ready) begin
            if (pending_triangles.size() == 0) begin
                report_mismatch("triangle with none pending", out_if.corner_a, '0);
            end else begin
                want = pending_triangles.pop_front();
                if (out_if.corner_a !== want.corner_a) begin
                    report_mismatch("corner_a", out_if.corner_a, want.corner_a);
                end
                if (out_if.corner_b !== want.corner_b) begin
                    report_mismatch("corner_b", out_if.corner_b, want.corner_b);
                end
                if (out_if.corner_c !== want.corner_c) begin
                    report_mismatch("corner_c", out_if.corner_c, want.corner_c);
                end
                if (out_if.last_of_run !== want.last_of_run) begin
                    report_mismatch("last_of_run", 32'(out_if.last_of_run),
                                    32'(want.last_of_run));
                end
            end
            stall_left = steady_flow ? 0 : $urandom_range(0, 4);
            if (stall_left > 0) begin
                sink_ready <= 1'b0;
            end
        end else if (!sink_ready) begin
            if (stall_left > 0) begin
                stall_left--;
            end
            if (stall_left == 0) begin
                sink_ready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.opcode <= OP_BEGIN;
        in_if.value  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        field_bits   = INDEX_BITS_RESET;
        restart_strip();
        left_count   = '0;
        mismatch_cnt = 0;
        useful_items = 0;
        steady_flow  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_width();
        test_single_bit_fields();
        test_full_width_fields();
        test_random_strips();
        settle();

        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
